/* hw/rtl/irc_tok_pkg.sv */
// Shared types and codes for the IRC message tokenizer.
package irc_tok_pkg;

    // Parser position within the line
    typedef enum logic [3:0] {
        PH_START,
        PH_TAGS,
        PH_KEY,
        PH_VAL,
        PH_AFTER_TAGS,
        PH_SRC_OPEN,
        PH_SOURCE,
        PH_AFTER_SRC,
        PH_CMD,
        PH_ARGSKIP,
        PH_MIDDLE,
        PH_REST,
        PH_DRAIN
    } t_phase;

    // Field kinds
    localparam logic [2:0] KIND_TAG_KEY = 3'd0;
    localparam logic [2:0] KIND_TAG_VAL = 3'd1;
    localparam logic [2:0] KIND_SOURCE  = 3'd2;
    localparam logic [2:0] KIND_COMMAND = 3'd3;
    localparam logic [2:0] KIND_MIDDLE  = 3'd4;
    localparam logic [2:0] KIND_REST    = 3'd5;

    // Message status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_EMPTY_TAG = 3'd1;
    localparam logic [2:0] STAT_TOO_MANY  = 3'd2;
    localparam logic [2:0] STAT_EMPTY_SRC = 3'd3;
    localparam logic [2:0] STAT_NO_CMD    = 3'd4;

    // Input request: one line byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in_req;

    // Output request: one tokenizer result
    typedef struct packed {
        logic [2:0] field_kind;
        logic [4:0] field_index;
        logic [7:0] char_out;
        logic       char_valid;
        logic       field_end;
        logic       message_end;
        logic [2:0] status;
        logic [5:0] tag_count;
        logic [3:0] arg_count;
    } t_out_req;

    // Parser state carried between bytes
    typedef struct packed {
        t_phase     phase;
        logic       esc;
        logic [5:0] tag_cnt;
        logic [3:0] arg_cnt;
        logic [2:0] err;
    } t_state;

endpackage

/* hw/rtl/irc_message_tokenizer.sv */
// Top level of the IRC line tokenizer with message tag parsing.
//
// Input channel: one line byte per request (data, last) on i_in_valid /
// o_in_stall. Output channel: at most one result per byte on o_out_valid /
// i_out_stall; each result tags a content byte with its field kind and
// index, marks field ends, and on the last byte of a line carries
// message_end with the status and the tag and argument counts.
// A byte is captured in an input register, decoded by the parser step
// logic once the output register is free, and its result lands in the
// output register. Bytes that only advance the parser produce nothing.
// Throughput is one byte per cycle while the receiver does not stall, set
// by the single parser state update per byte. While the receiver stalls a
// held result, one more byte is taken into the input register; after that
// o_in_stall rises.
// Reset empties both registers and returns the parser to start of line;
// the parser also returns there after every last byte.
module irc_message_tokenizer #(
    parameter int MAX_TAGS      = 32,
    parameter int MAX_ARGUMENTS = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  irc_tok_pkg::t_in_req  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output irc_tok_pkg::t_out_req o_out
);

    logic                  r_in_valid;
    irc_tok_pkg::t_in_req  r_in;
    logic                  r_out_valid;
    irc_tok_pkg::t_out_req r_out;
    irc_tok_pkg::t_state   r_state;

    irc_tok_pkg::t_state   n_state;
    irc_tok_pkg::t_out_req n_out;
    logic                  n_out_has;
    logic                  w_fire;
    logic                  w_out_free;
    logic                  w_in_take;

    // Handshake control
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    irc_tok_step #(
        .MAX_TAGS      (MAX_TAGS),
        .MAX_ARGUMENTS (MAX_ARGUMENTS)
    ) u_step (
        .i_state     (r_state),
        .i_req       (r_in),
        .o_state     (n_state),
        .o_res       (n_out),
        .o_res_valid (n_out_has)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: irc_tok_pkg::PH_START, esc: 1'b0, tag_cnt: 6'd0,
                             arg_cnt: 4'd0, err: 3'd0};
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= n_out_has;
                r_state     <= n_state;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in;
        end
        if (w_fire && n_out_has) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Parser is back at start of line after a last byte
    a_line_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.last) |=>
            (r_state.phase == irc_tok_pkg::PH_START && r_state.tag_cnt == 6'd0
             && r_state.arg_cnt == 4'd0 && !r_state.esc))
        else $error("parser state not cleared after line end");

    // A last byte always yields a message-end result
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.last) |=> (r_out_valid && r_out.message_end))
        else $error("line end produced no message-end result");

    // Summary fields stay zero except at message end
    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.message_end) |->
            (o_out.status == irc_tok_pkg::STAT_OK && o_out.tag_count == 6'd0
             && o_out.arg_count == 4'd0))
        else $error("summary fields set before message end");

    // Tag count never exceeds the limit
    a_tag_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.tag_cnt <= 6'(MAX_TAGS))
        else $error("tag counter above limit");

endmodule

/* hw/rtl/irc_tok_step.sv */
// Per-byte parser step: next state and result for one line byte.
module irc_tok_step #(
    parameter int MAX_TAGS      = 32,
    parameter int MAX_ARGUMENTS = 15
) (
    input  irc_tok_pkg::t_state   i_state,
    input  irc_tok_pkg::t_in_req  i_req,
    output irc_tok_pkg::t_state   o_state,
    output irc_tok_pkg::t_out_req o_res,
    output logic                  o_res_valid
);

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [5:0] MaxTags  = 6'(MAX_TAGS);
    localparam logic [3:0] LastSlot = 4'(MAX_ARGUMENTS - 1);

    // Value escape decode
    function automatic logic [7:0] unescape(input logic [7:0] c);
        unique case (c)
            CH_COLON: unescape = CH_SEMI;
            CH_S:     unescape = CH_SPACE;
            CH_R:     unescape = CH_CR;
            CH_N:     unescape = CH_LF;
            default:  unescape = c;
        endcase
    endfunction

    logic [7:0]  c;
    logic        w_last;
    logic [4:0]  tag_idx_cur;
    logic [4:0]  arg_idx_cur;
    logic [5:0]  tag_dec;
    logic [3:0]  arg_dec;
    logic [4:0]  tag_idx_nxt;
    logic [4:0]  arg_idx_nxt;
    irc_tok_pkg::t_state   w_nxt;
    irc_tok_pkg::t_out_req w_res;
    logic        w_any;
    logic        w_lone;
    logic [2:0]  w_status;

    assign c           = i_req.data;
    assign w_last      = i_req.last;
    assign tag_dec     = i_state.tag_cnt - 6'd1;
    assign arg_dec     = i_state.arg_cnt - 4'd1;
    assign tag_idx_cur = tag_dec[4:0];
    assign arg_idx_cur = {1'b0, arg_dec};

    // Byte decode per phase
    always_comb begin
        w_nxt  = i_state;
        w_res  = '0;
        w_any  = 1'b0;
        w_lone = 1'b0;
        unique case (i_state.phase)
            irc_tok_pkg::PH_START, irc_tok_pkg::PH_AFTER_TAGS,
            irc_tok_pkg::PH_AFTER_SRC: begin
                if (i_state.phase == irc_tok_pkg::PH_START && c == CH_AT) begin
                    w_nxt.phase = irc_tok_pkg::PH_TAGS;
                    w_lone      = 1'b1;
                end else if (i_state.phase != irc_tok_pkg::PH_START && c == CH_SPACE) begin
                    // skip separator spaces
                end else if (i_state.phase != irc_tok_pkg::PH_AFTER_SRC
                             && c == CH_COLON) begin
                    w_nxt.phase = irc_tok_pkg::PH_SRC_OPEN;
                end else if (c == CH_SPACE) begin
                    // empty command
                    w_res.field_kind = irc_tok_pkg::KIND_COMMAND;
                    w_res.field_end  = 1'b1;
                    w_any            = 1'b1;
                    w_nxt.phase      = irc_tok_pkg::PH_ARGSKIP;
                end else begin
                    w_res.field_kind = irc_tok_pkg::KIND_COMMAND;
                    w_res.char_out   = c;
                    w_res.char_valid = 1'b1;
                    w_any            = 1'b1;
                    w_nxt.phase      = irc_tok_pkg::PH_CMD;
                end
            end
            irc_tok_pkg::PH_TAGS: begin
                if (c == CH_SEMI) begin
                    // empty token
                end else if (c == CH_SPACE) begin
                    w_nxt.esc   = 1'b0;
                    w_nxt.phase = irc_tok_pkg::PH_AFTER_TAGS;
                end else if (i_state.tag_cnt >= MaxTags) begin
                    w_nxt.err   = irc_tok_pkg::STAT_TOO_MANY;
                    w_nxt.phase = irc_tok_pkg::PH_DRAIN;
                end else begin
                    w_nxt.tag_cnt     = i_state.tag_cnt + 6'd1;
                    w_res.field_kind  = irc_tok_pkg::KIND_TAG_KEY;
                    w_res.field_index = i_state.tag_cnt[4:0];
                    w_any             = 1'b1;
                    if (c == CH_EQ) begin
                        w_res.field_end = 1'b1;
                        w_nxt.phase     = irc_tok_pkg::PH_VAL;
                    end else begin
                        w_res.char_out   = c;
                        w_res.char_valid = 1'b1;
                        w_nxt.phase      = irc_tok_pkg::PH_KEY;
                    end
                end
            end
            irc_tok_pkg::PH_KEY: begin
                w_res.field_kind  = irc_tok_pkg::KIND_TAG_KEY;
                w_res.field_index = tag_idx_cur;
                w_any             = 1'b1;
                if (c == CH_SEMI || c == CH_SPACE || c == CH_EQ) begin
                    w_res.field_end = 1'b1;
                    w_nxt.esc       = (c == CH_EQ) ? i_state.esc : 1'b0;
                    priority case (1'b1)
                        c == CH_SEMI:  w_nxt.phase = irc_tok_pkg::PH_TAGS;
                        c == CH_SPACE: w_nxt.phase = irc_tok_pkg::PH_AFTER_TAGS;
                        default:       w_nxt.phase = irc_tok_pkg::PH_VAL;
                    endcase
                end else begin
                    w_res.char_out   = c;
                    w_res.char_valid = 1'b1;
                end
            end
            irc_tok_pkg::PH_VAL: begin
                w_res.field_kind  = irc_tok_pkg::KIND_TAG_VAL;
                w_res.field_index = tag_idx_cur;
                if (c == CH_SEMI || c == CH_SPACE) begin
                    w_res.field_end = 1'b1;
                    w_any           = 1'b1;
                    w_nxt.esc       = 1'b0;
                    w_nxt.phase     = (c == CH_SEMI) ? irc_tok_pkg::PH_TAGS
                                                     : irc_tok_pkg::PH_AFTER_TAGS;
                end else if (i_state.esc) begin
                    w_nxt.esc        = 1'b0;
                    w_res.char_out   = unescape(c);
                    w_res.char_valid = 1'b1;
                    w_any            = 1'b1;
                end else if (c == CH_BSL) begin
                    w_nxt.esc         = 1'b1;
                    w_res.field_kind  = '0;
                    w_res.field_index = '0;
                end else begin
                    w_res.char_out   = c;
                    w_res.char_valid = 1'b1;
                    w_any            = 1'b1;
                end
            end
            irc_tok_pkg::PH_SRC_OPEN, irc_tok_pkg::PH_SOURCE: begin
                w_res.field_kind = irc_tok_pkg::KIND_SOURCE;
                w_any            = 1'b1;
                if (c == CH_SPACE) begin
                    w_res.field_end = 1'b1;
                    w_nxt.phase     = irc_tok_pkg::PH_AFTER_SRC;
                end else begin
                    w_res.char_out   = c;
                    w_res.char_valid = 1'b1;
                    w_nxt.phase      = irc_tok_pkg::PH_SOURCE;
                end
            end
            irc_tok_pkg::PH_CMD: begin
                w_res.field_kind = irc_tok_pkg::KIND_COMMAND;
                w_any            = 1'b1;
                if (c == CH_SPACE) begin
                    w_res.field_end = 1'b1;
                    w_nxt.phase     = irc_tok_pkg::PH_ARGSKIP;
                end else begin
                    w_res.char_out   = c;
                    w_res.char_valid = 1'b1;
                end
            end
            irc_tok_pkg::PH_ARGSKIP: begin
                if (c != CH_SPACE) begin
                    w_nxt.arg_cnt = i_state.arg_cnt + 4'd1;
                    if (c == CH_COLON) begin
                        w_nxt.phase = irc_tok_pkg::PH_REST;
                    end else begin
                        w_res.field_index = {1'b0, i_state.arg_cnt};
                        w_res.char_out    = c;
                        w_res.char_valid  = 1'b1;
                        w_any             = 1'b1;
                        if (i_state.arg_cnt == LastSlot) begin
                            w_res.field_kind = irc_tok_pkg::KIND_REST;
                            w_nxt.phase      = irc_tok_pkg::PH_REST;
                        end else begin
                            w_res.field_kind = irc_tok_pkg::KIND_MIDDLE;
                            w_nxt.phase      = irc_tok_pkg::PH_MIDDLE;
                        end
                    end
                end
            end
            irc_tok_pkg::PH_MIDDLE: begin
                w_res.field_kind  = irc_tok_pkg::KIND_MIDDLE;
                w_res.field_index = arg_idx_cur;
                w_any             = 1'b1;
                if (c == CH_SPACE) begin
                    w_res.field_end = 1'b1;
                    w_nxt.phase     = irc_tok_pkg::PH_ARGSKIP;
                end else begin
                    w_res.char_out   = c;
                    w_res.char_valid = 1'b1;
                end
            end
            irc_tok_pkg::PH_REST: begin
                w_res.field_kind  = irc_tok_pkg::KIND_REST;
                w_res.field_index = arg_idx_cur;
                w_res.char_out    = c;
                w_res.char_valid  = 1'b1;
                w_any             = 1'b1;
            end
            default: begin
                w_nxt.phase = irc_tok_pkg::PH_DRAIN;
            end
        endcase
    end

    // Indexes as seen after this byte's counter updates
    logic [5:0] tag_dec_nxt;
    logic [3:0] arg_dec_nxt;
    assign tag_dec_nxt = w_nxt.tag_cnt - 6'd1;
    assign arg_dec_nxt = w_nxt.arg_cnt - 4'd1;
    assign tag_idx_nxt = tag_dec_nxt[4:0];
    assign arg_idx_nxt = {1'b0, arg_dec_nxt};

    // Line end: status, closing of an open field, state back to start
    always_comb begin
        o_res       = w_res;
        o_state     = w_nxt;
        o_res_valid = w_any || w_last;
        w_status    = irc_tok_pkg::STAT_OK;
        if (w_last) begin
            if (w_lone) begin
                w_status = irc_tok_pkg::STAT_EMPTY_TAG;
            end else begin
                unique case (w_nxt.phase)
                    irc_tok_pkg::PH_TAGS, irc_tok_pkg::PH_KEY, irc_tok_pkg::PH_VAL,
                    irc_tok_pkg::PH_AFTER_TAGS, irc_tok_pkg::PH_SOURCE,
                    irc_tok_pkg::PH_AFTER_SRC:
                        w_status = irc_tok_pkg::STAT_NO_CMD;
                    irc_tok_pkg::PH_SRC_OPEN: w_status = irc_tok_pkg::STAT_EMPTY_SRC;
                    irc_tok_pkg::PH_DRAIN:    w_status = w_nxt.err;
                    default:                  w_status = irc_tok_pkg::STAT_OK;
                endcase
            end
            if (!w_res.field_end) begin
                unique case (w_nxt.phase)
                    irc_tok_pkg::PH_KEY: begin
                        o_res.field_kind  = irc_tok_pkg::KIND_TAG_KEY;
                        o_res.field_index = tag_idx_nxt;
                        o_res.field_end   = 1'b1;
                    end
                    irc_tok_pkg::PH_VAL: begin
                        o_res.field_kind  = irc_tok_pkg::KIND_TAG_VAL;
                        o_res.field_index = tag_idx_nxt;
                        o_res.field_end   = 1'b1;
                    end
                    irc_tok_pkg::PH_SOURCE: begin
                        o_res.field_kind  = irc_tok_pkg::KIND_SOURCE;
                        o_res.field_index = '0;
                        o_res.field_end   = 1'b1;
                    end
                    irc_tok_pkg::PH_CMD: begin
                        o_res.field_kind  = irc_tok_pkg::KIND_COMMAND;
                        o_res.field_index = '0;
                        o_res.field_end   = 1'b1;
                    end
                    irc_tok_pkg::PH_MIDDLE: begin
                        o_res.field_kind  = irc_tok_pkg::KIND_MIDDLE;
                        o_res.field_index = arg_idx_nxt;
                        o_res.field_end   = 1'b1;
                    end
                    irc_tok_pkg::PH_REST: begin
                        o_res.field_kind  = irc_tok_pkg::KIND_REST;
                        o_res.field_index = arg_idx_nxt;
                        o_res.field_end   = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            o_res.message_end = 1'b1;
            o_res.status      = w_status;
            o_res.tag_count   = w_nxt.tag_cnt;
            o_res.arg_count   = w_nxt.arg_cnt;
            o_state           = '0;
            o_state.phase     = irc_tok_pkg::PH_START;
        end
    end

endmodule

/* bench/irc_message_tokenizer_test.sv */
// Self-checking testbench for the IRC line tokenizer: directed lines, random lines, backpressure.
`timescale 1ns / 1ps

module irc_message_tokenizer_test;
    import irc_tok_pkg::*;

    localparam int MAX_TAGS       = 32;
    localparam int MAX_ARGUMENTS  = 15;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // Delimiter bytes
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5c;

    logic     i_clk     = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_in_req  in_req    = '0;
    logic     out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out;

    irc_message_tokenizer #(
        .MAX_TAGS      (MAX_TAGS),
        .MAX_ARGUMENTS (MAX_ARGUMENTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Traffic shaping knobs, set by the test tasks
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    bit hold_go        = 1'b0;
    bit hold_ack       = 1'b0;
    int hold_left      = 0;

    int mismatches    = 0;
    int stray_results = 0;
    int quiet_cycles  = 0;

    t_out_req   expected_tokens[$];
    logic [7:0] line_bytes[$];

    string alnum_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.!";
    string delim_chars  = "@:;= \\srn";
    string escape_chars = ":srn\\aq";

    // ------------------------------------------------------------------
    // Tokenizer predictor state
    // ------------------------------------------------------------------
    t_phase     tok_phase = PH_START;
    logic       tok_esc   = 1'b0;
    logic [5:0] tok_tags  = '0;
    logic [3:0] tok_args  = '0;
    logic [2:0] tok_err   = STAT_OK;
    t_out_req   tok_res;
    logic       tok_any;

    function automatic void clear_parser();
        tok_phase = PH_START;
        tok_esc   = 1'b0;
        tok_tags  = '0;
        tok_args  = '0;
        tok_err   = STAT_OK;
    endfunction

    function automatic void emit_char(input logic [2:0] kind, input logic [4:0] idx,
                                      input logic [7:0] c);
        tok_res.field_kind  = kind;
        tok_res.field_index = idx;
        tok_res.char_out    = c;
        tok_res.char_valid  = 1'b1;
        tok_any             = 1'b1;
    endfunction

    function automatic void close_field(input logic [2:0] kind, input logic [4:0] idx);
        tok_res.field_kind  = kind;
        tok_res.field_index = idx;
        tok_res.field_end   = 1'b1;
        tok_any             = 1'b1;
    endfunction

    function automatic logic [4:0] tag_slot();
        return 5'(tok_tags - 6'd1);
    endfunction

    function automatic logic [4:0] arg_slot();
        return {1'b0, 4'(tok_args - 4'd1)};
    endfunction

    function automatic logic [7:0] unescape_value(input logic [7:0] c);
        case (c)
            CH_COLON: return CH_SEMI;
            "s":      return CH_SP;
            "r":      return 8'h0d;
            "n":      return 8'h0a;
            default:  return c;
        endcase
    endfunction

    function automatic void begin_command(input logic [7:0] c);
        if (c == CH_SP) begin
            close_field(KIND_COMMAND, 5'd0);
            tok_phase = PH_ARGSKIP;
        end else begin
            emit_char(KIND_COMMAND, 5'd0, c);
            tok_phase = PH_CMD;
        end
    endfunction

    function automatic void begin_prefix(input logic [7:0] c);
        if (c == CH_COLON) tok_phase = PH_SRC_OPEN;
        else begin_command(c);
    endfunction

    function automatic void close_tag(input t_phase nxt);
        tok_esc   = 1'b0;
        tok_phase = nxt;
    endfunction

    // Advance the predicted parser by one byte and queue any result
    function automatic void tokenize_byte(input logic [7:0] c, input logic lst);
        logic       lone_at;
        logic [3:0] slot;
        logic [2:0] stat;
        lone_at = 1'b0;
        tok_res = '0;
        tok_any = 1'b0;
        case (tok_phase)
            PH_START: begin
                if (c == CH_AT) begin
                    tok_phase = PH_TAGS;
                    lone_at   = 1'b1;
                end else begin
                    begin_prefix(c);
                end
            end
            PH_TAGS: begin
                if (c == CH_SP) begin
                    close_tag(PH_AFTER_TAGS);
                end else if (c != CH_SEMI) begin
                    if (tok_tags >= MAX_TAGS) begin
                        // overflow: swallow the rest of the line
                        tok_err   = STAT_TOO_MANY;
                        tok_phase = PH_DRAIN;
                    end else begin
                        tok_tags = tok_tags + 6'd1;
                        if (c == CH_EQ) begin
                            close_field(KIND_TAG_KEY, tag_slot());
                            tok_phase = PH_VAL;
                        end else begin
                            emit_char(KIND_TAG_KEY, tag_slot(), c);
                            tok_phase = PH_KEY;
                        end
                    end
                end
            end
            PH_KEY: begin
                if (c == CH_SEMI) begin
                    close_field(KIND_TAG_KEY, tag_slot());
                    close_tag(PH_TAGS);
                end else if (c == CH_SP) begin
                    close_field(KIND_TAG_KEY, tag_slot());
                    close_tag(PH_AFTER_TAGS);
                end else if (c == CH_EQ) begin
                    close_field(KIND_TAG_KEY, tag_slot());
                    tok_phase = PH_VAL;
                end else begin
                    emit_char(KIND_TAG_KEY, tag_slot(), c);
                end
            end
            PH_VAL: begin
                if (c == CH_SEMI) begin
                    close_field(KIND_TAG_VAL, tag_slot());
                    close_tag(PH_TAGS);
                end else if (c == CH_SP) begin
                    close_field(KIND_TAG_VAL, tag_slot());
                    close_tag(PH_AFTER_TAGS);
                end else if (tok_esc) begin
                    tok_esc = 1'b0;
                    emit_char(KIND_TAG_VAL, tag_slot(), unescape_value(c));
                end else if (c == CH_BSL) begin
                    tok_esc = 1'b1;
                end else begin
                    emit_char(KIND_TAG_VAL, tag_slot(), c);
                end
            end
            PH_AFTER_TAGS: begin
                if (c != CH_SP) begin_prefix(c);
            end
            PH_SRC_OPEN, PH_SOURCE: begin
                if (c == CH_SP) begin
                    close_field(KIND_SOURCE, 5'd0);
                    tok_phase = PH_AFTER_SRC;
                end else begin
                    emit_char(KIND_SOURCE, 5'd0, c);
                    tok_phase = PH_SOURCE;
                end
            end
            PH_AFTER_SRC: begin
                if (c != CH_SP) begin_command(c);
            end
            PH_CMD: begin
                if (c == CH_SP) begin
                    close_field(KIND_COMMAND, 5'd0);
                    tok_phase = PH_ARGSKIP;
                end else begin
                    emit_char(KIND_COMMAND, 5'd0, c);
                end
            end
            PH_ARGSKIP: begin
                if (c != CH_SP) begin
                    slot     = tok_args;
                    tok_args = tok_args + 4'd1;
                    if (c == CH_COLON) begin
                        tok_phase = PH_REST;
                    end else if (int'(slot) + 1 == MAX_ARGUMENTS) begin
                        // last slot takes the rest of the line
                        emit_char(KIND_REST, {1'b0, slot}, c);
                        tok_phase = PH_REST;
                    end else begin
                        emit_char(KIND_MIDDLE, {1'b0, slot}, c);
                        tok_phase = PH_MIDDLE;
                    end
                end
            end
            PH_MIDDLE: begin
                if (c == CH_SP) begin
                    close_field(KIND_MIDDLE, arg_slot());
                    tok_phase = PH_ARGSKIP;
                end else begin
                    emit_char(KIND_MIDDLE, arg_slot(), c);
                end
            end
            PH_REST: begin
                emit_char(KIND_REST, arg_slot(), c);
            end
            default: begin
                tok_phase = PH_DRAIN;
            end
        endcase

        if (lst) begin
            if (lone_at) begin
                stat = STAT_EMPTY_TAG;
            end else begin
                case (tok_phase)
                    PH_TAGS, PH_KEY, PH_VAL, PH_AFTER_TAGS, PH_SOURCE, PH_AFTER_SRC:
                        stat = STAT_NO_CMD;
                    PH_SRC_OPEN: stat = STAT_EMPTY_SRC;
                    PH_DRAIN:    stat = tok_err;
                    default:     stat = STAT_OK;
                endcase
            end
            // close whatever field is still open
            if (!tok_res.field_end) begin
                case (tok_phase)
                    PH_KEY:    close_field(KIND_TAG_KEY, tag_slot());
                    PH_VAL:    close_field(KIND_TAG_VAL, tag_slot());
                    PH_SOURCE: close_field(KIND_SOURCE, 5'd0);
                    PH_CMD:    close_field(KIND_COMMAND, 5'd0);
                    PH_MIDDLE: close_field(KIND_MIDDLE, arg_slot());
                    PH_REST:   close_field(KIND_REST, arg_slot());
                    default:   ;
                endcase
            end
            tok_res.message_end = 1'b1;
            tok_res.status      = stat;
            tok_res.tag_count   = tok_tags;
            tok_res.arg_count   = tok_args;
            expected_tokens.push_back(tok_res);
            clear_parser();
        end else if (tok_any) begin
            expected_tokens.push_back(tok_res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{data: b, last: lst};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tokenize_byte(b, lst);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_bytes.size(); i++)
            send_byte(line_bytes[i], i == line_bytes.size() - 1);
    endtask

    task automatic send_text(input string s);
        line_bytes.delete();
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
        send_line();
    endtask

    // Byte biased toward delimiters, otherwise anything
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(2))
            0:       return delim_chars[$urandom_range(delim_chars.len() - 1)];
            1:       return 8'($urandom_range(255));
            default: return alnum_chars[$urandom_range(alnum_chars.len() - 1)];
        endcase
    endfunction

    // Append len content bytes, none of them equal to x0, x1 or x2
    task automatic push_word(input int len, input logic [7:0] x0, x1, x2);
        logic [7:0] c;
        repeat (len) begin
            do begin
                if ($urandom_range(3) == 0) c = 8'($urandom_range(255));
                else c = alnum_chars[$urandom_range(alnum_chars.len() - 1)];
            end while (c == x0 || c == x1 || c == x2);
            line_bytes.push_back(c);
        end
    endtask

    task automatic push_spaces();
        repeat ($urandom_range(2, 1)) line_bytes.push_back(CH_SP);
    endtask

    // Mostly well-formed lines with random content, some broken or pure noise
    task automatic build_random_line();
        int n_tag;
        int n_arg;
        int len;
        line_bytes.delete();
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(12, 1)) line_bytes.push_back(noise_byte());
            return;
        end

        // tag section
        if ($urandom_range(99) < 45) begin
            line_bytes.push_back(CH_AT);
            n_tag = ($urandom_range(99) < 5) ? $urandom_range(36, 30) : $urandom_range(4, 1);
            for (int t = 0; t < n_tag; t++) begin
                if (t != 0) line_bytes.push_back(CH_SEMI);
                if ($urandom_range(9) == 0) line_bytes.push_back(CH_SEMI);
                len = ($urandom_range(19) == 0) ? 0 : $urandom_range(4, 1);
                push_word(len, CH_SEMI, CH_SP, CH_EQ);
                if ($urandom_range(99) < 60 || len == 0) begin
                    line_bytes.push_back(CH_EQ);
                    repeat ($urandom_range(5)) begin
                        if ($urandom_range(3) == 0) begin
                            line_bytes.push_back(CH_BSL);
                            if ($urandom_range(4) == 0) line_bytes.push_back(noise_byte());
                            else line_bytes.push_back(
                                escape_chars[$urandom_range(escape_chars.len() - 1)]);
                        end else begin
                            push_word(1, CH_SEMI, CH_SP, CH_BSL);
                        end
                    end
                end
            end
            if ($urandom_range(9) == 0) line_bytes.push_back(CH_SEMI);
            if ($urandom_range(99) < 8) return;
            push_spaces();
        end

        // source
        if ($urandom_range(99) < 40) begin
            line_bytes.push_back(CH_COLON);
            push_word($urandom_range(5), CH_SP, CH_SP, CH_SP);
            if ($urandom_range(99) < 6) return;
            push_spaces();
        end

        // command, rarely empty
        if ($urandom_range(29) != 0) begin
            push_word(1, CH_SP, CH_COLON, CH_AT);
            push_word($urandom_range(4), CH_SP, CH_SP, CH_SP);
        end

        // arguments, sometimes past the last slot
        n_arg = ($urandom_range(99) < 10) ? $urandom_range(17, 13) : $urandom_range(4);
        for (int a = 0; a < n_arg; a++) begin
            push_spaces();
            if (a == n_arg - 1 && $urandom_range(99) < 35) begin
                line_bytes.push_back(CH_COLON);
                repeat ($urandom_range(6)) line_bytes.push_back(noise_byte());
            end else begin
                push_word(1, CH_SP, CH_COLON, CH_COLON);
                push_word($urandom_range(3), CH_SP, CH_SP, CH_SP);
            end
        end
        if ($urandom_range(9) == 0) push_spaces();
        if (line_bytes.size() == 0) line_bytes.push_back(CH_SP);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern, long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_go != hold_ack) begin
            hold_ack  <= hold_go;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_tokens
        t_out_req want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_tokens.size() == 0) begin
                stray_results = stray_results + 1;
                if (mismatches + stray_results <= 10)
                    $display("token with nothing pending: %h", o_out);
            end else begin
                want = expected_tokens.pop_front();
                if (o_out.field_kind  !== want.field_kind  ||
                    o_out.field_index !== want.field_index ||
                    o_out.char_out    !== want.char_out    ||
                    o_out.char_valid  !== want.char_valid  ||
                    o_out.field_end   !== want.field_end   ||
                    o_out.message_end !== want.message_end ||
                    o_out.status      !== want.status      ||
                    o_out.tag_count   !== want.tag_count   ||
                    o_out.arg_count   !== want.arg_count) begin
                    mismatches = mismatches + 1;
                    if (mismatches + stray_results <= 10)
                        $display({"token mismatch kind/idx/char/cv/fe/me/st/tags/args ",
                                  "expected %0d/%0d/%h/%b/%b/%b/%0d/%0d/%0d ",
                                  "got %0d/%0d/%h/%b/%b/%b/%0d/%0d/%0d"},
                                 want.field_kind, want.field_index, want.char_out,
                                 want.char_valid, want.field_end, want.message_end,
                                 want.status, want.tag_count, want.arg_count,
                                 o_out.field_kind, o_out.field_index, o_out.char_out,
                                 o_out.char_valid, o_out.field_end, o_out.message_end,
                                 o_out.status, o_out.tag_count, o_out.arg_count);
                end
            end
        end
    end

    // Watchdog on cycles where neither channel moves a request
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_special_lines();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        send_text("@");                       // lone at sign
        send_text(":");                       // empty source
        send_text("@a=");                     // ends on '='
        send_text("@k=\\:\\s\\r\\n\\q\\");    // all escapes, trailing backslash
        send_text("@k=\\ x");                 // backslash before a delimiter
        send_text(" a");                      // empty command
        send_text(": C");                     // empty source then command
        send_text("C a  ");                   // trailing spaces
        // zero byte and top byte as content
        line_bytes.delete();
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'hff);
        line_bytes.push_back(CH_SP);
        line_bytes.push_back(8'hff);
        send_line();
    endtask

    task automatic test_random_lines(input int gap_pct, input int stall_pct, input int n_bytes);
        int sent;
        sent           = 0;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_bytes) begin
            build_random_line();
            sent += line_bytes.size();
            send_line();
        end
    endtask

    // Receiver holds off while the sender keeps pushing, so the input stalls
    task automatic test_input_backpressure();
        int sent;
        sent           = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_go        = ~hold_go;
        while (sent < 80) begin
            build_random_line();
            sent += line_bytes.size();
            send_line();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_lines();
        test_random_lines(21, 80, 500);
        test_random_lines(80, 21, 500);
        test_random_lines(0, 0, 500);
        test_input_backpressure();

        // let the block drain
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && stray_results == 0 && expected_tokens.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
